/* rtl/core/thm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thm_pkg
// Shared constants and types for the thermistor ADC to temperature core.
// ----------------------------------------------------------------------------
package thm_pkg;

    localparam int ADC_BITS  = 10;
    localparam int ADC_W     = 10;
    localparam int MV_W      = 12;
    localparam int R_W       = 23;
    localparam int D_W       = 14;
    localparam int SLOPE_W   = 14;
    localparam int START_W   = 16;
    localparam int C_W       = 13;
    localparam int F_W       = 14;
    localparam int SEG_N     = 6;
    localparam int SEG_IDX_W = 3;

    // Serial divider operand widths
    localparam int NUM_W     = 26;
    localparam int DEN_W     = 15;
    localparam int CNT_W     = $clog2(NUM_W + 1);

    localparam int VREF_MV   = 3300;
    localparam int PULL_OHMS = 10000;
    localparam int R_MAX     = 33970;
    localparam int R_MIN     = 2484;

    // Doubled scale factors for round-to-nearest: (2*d*k + s) / (2*s)
    localparam int C_SCALE2  = 2000;
    localparam int F_SCALE2  = 3600;
    localparam int C_SEG_STEP = 1000;
    localparam int F_SEG_STEP = 1800;
    localparam int F_OFFSET   = 3200;
    localparam int C_MAX      = 6000;
    localparam int F_MAX      = 14000;

    localparam logic [START_W-1:0] SEG_START [SEG_N] =
        '{16'd33970, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586};
    localparam logic [START_W-1:0] SEG_END [SEG_N] =
        '{16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
    localparam logic [SLOPE_W-1:0] SEG_SLOPE [SEG_N] =
        '{14'd13660, 14'd7740, 14'd4537, 14'd2737, 14'd1717, 14'd1102};

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic                 ok;
        logic [SEG_IDX_W-1:0] idx;
        logic [START_W-1:0]   start;
        logic [SLOPE_W-1:0]   slope;
    } seg_t;

endpackage
`default_nettype wire

/* rtl/core/thermistor_adc_to_temperature_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// Converts a thermistor ADC code to Celsius and Fahrenheit in 0.01 degrees
// through a six-segment piecewise-linear curve.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid, in_ready, adc_code                    | in
//   out     | out_valid, out_ready, celsius_centi,            | out
//           | fahrenheit_centi, in_range                      |
//
// An in-range transaction makes three passes through the shared bit-serial
// divider (resistance, Celsius fraction, Fahrenheit fraction), each giving 26
// quotient bits; an out-of-range one makes only the resistance pass.
// Reset clears the held temperature to 0 C / 32 F.
// A new transaction is taken while the previous result still waits; the
// finished result then waits for the output register to free up.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [thm_pkg::ADC_W-1:0] adc_code,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [thm_pkg::C_W-1:0]        celsius_centi,
    output logic [thm_pkg::F_W-1:0]        fahrenheit_centi,
    output logic                           in_range
);
    import thm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MV,
        ST_RDIV,
        ST_RWAIT,
        ST_SEG,
        ST_CDIV,
        ST_CWAIT,
        ST_FDIV,
        ST_FWAIT,
        ST_OUT
    } state_t;

    localparam int MV_PROD_W = ADC_W + MV_W + 2;

    state_t               state_reg;
    logic [ADC_W-1:0]     code_reg;
    logic [MV_W-1:0]      mv_reg;
    logic [R_W-1:0]       r_reg;
    logic [D_W-1:0]       d_reg;
    logic [SLOPE_W-1:0]   slope_reg;
    logic [SEG_IDX_W-1:0] idx_reg;
    logic                 ok_reg;
    logic [C_W-1:0]       c_new_reg;
    logic [F_W-1:0]       f_new_reg;
    logic [C_W-1:0]       held_c_reg;
    logic [F_W-1:0]       held_f_reg;
    logic                 in_range_reg;
    logic                 out_valid_reg;

    logic [MV_PROD_W-1:0] mv_prod;
    logic [MV_W-1:0]      mv_next;
    logic [START_W-1:0]   d_next;
    div_req_t             div_req;
    div_rsp_t             div_rsp;
    seg_t                 seg;
    logic                 out_free;

    thm_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    thm_seg_sel u_seg (
        .r   (r_reg),
        .seg (seg)
    );

    assign mv_prod  = MV_PROD_W'(code_reg) * MV_PROD_W'(VREF_MV);
    assign mv_next  = MV_W'(mv_prod >> ADC_BITS);
    assign d_next   = seg.start - START_W'(r_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            ST_RDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(mv_reg) * NUM_W'(PULL_OHMS);
                div_req.den   = DEN_W'(VREF_MV) - DEN_W'(mv_reg);
            end
            ST_CDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(d_reg) * NUM_W'(C_SCALE2) + NUM_W'(slope_reg);
                div_req.den   = {slope_reg, 1'b0};
            end
            ST_FDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = NUM_W'(d_reg) * NUM_W'(F_SCALE2) + NUM_W'(slope_reg);
                div_req.den   = {slope_reg, 1'b0};
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_c_reg    <= '0;
            held_f_reg    <= F_W'(F_OFFSET);
            in_range_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            code_reg      <= '0;
            mv_reg        <= '0;
            r_reg         <= '0;
            d_reg         <= '0;
            slope_reg     <= '0;
            idx_reg       <= '0;
            ok_reg        <= 1'b0;
            c_new_reg     <= '0;
            f_new_reg     <= '0;
        end
        else
        begin
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        code_reg  <= adc_code;
                        state_reg <= ST_MV;
                    end
                end
                ST_MV:
                begin
                    mv_reg    <= mv_next;
                    state_reg <= ST_RDIV;
                end
                ST_RDIV:
                begin
                    state_reg <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        r_reg     <= R_W'(div_rsp.quo);
                        state_reg <= ST_SEG;
                    end
                end
                ST_SEG:
                begin
                    ok_reg    <= seg.ok;
                    d_reg     <= D_W'(d_next);
                    slope_reg <= seg.slope;
                    idx_reg   <= seg.idx;
                    // Out of range: skip the fraction divisions, hold outputs
                    state_reg <= seg.ok ? ST_CDIV : ST_OUT;
                end
                ST_CDIV:
                begin
                    state_reg <= ST_CWAIT;
                end
                ST_CWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        c_new_reg <= C_W'(idx_reg) * C_W'(C_SEG_STEP) + C_W'(div_rsp.quo);
                        state_reg <= ST_FDIV;
                    end
                end
                ST_FDIV:
                begin
                    state_reg <= ST_FWAIT;
                end
                ST_FWAIT:
                begin
                    if (div_rsp.done)
                    begin
                        f_new_reg <= F_W'(F_OFFSET) + F_W'(idx_reg) * F_W'(F_SEG_STEP)
                                     + F_W'(div_rsp.quo);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        if (ok_reg)
                        begin
                            held_c_reg <= c_new_reg;
                            held_f_reg <= f_new_reg;
                        end
                        in_range_reg  <= ok_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign celsius_centi    = held_c_reg;
    assign fahrenheit_centi = held_f_reg;
    assign in_range         = in_range_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a transaction is in progress");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_RWAIT || state_reg == ST_CWAIT
                          || state_reg == ST_FWAIT))
        else $error("divider finished outside a wait state");

    a_result_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_range) |-> (celsius_centi <= C_W'(C_MAX)
                                     && fahrenheit_centi <= F_W'(F_MAX)
                                     && fahrenheit_centi >= F_W'(F_OFFSET)))
        else $error("in-range temperature outside 0..60 C");
`endif

endmodule
`default_nettype wire

/* rtl/core/thm_serial_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thm_serial_div
// Restoring divider, one quotient bit per cycle, numerator shifted MSB first.
// ----------------------------------------------------------------------------
module thm_serial_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire thm_pkg::div_req_t req,
    output thm_pkg::div_rsp_t      rsp
);
    import thm_pkg::*;

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             q_bit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                num_reg  <= req.num;
                den_reg  <= req.den;
                rem_reg  <= '0;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // Quotient bits fill the numerator register from the bottom
                rem_reg <= q_bit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                num_reg <= {num_reg[NUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;

endmodule
`default_nettype wire

/* rtl/core/thm_seg_sel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thm_seg_sel
// Range check and segment pick for a thermistor resistance.
// ----------------------------------------------------------------------------
module thm_seg_sel (
    input  wire logic [thm_pkg::R_W-1:0] r,
    output thm_pkg::seg_t                seg
);
    import thm_pkg::*;

    logic [SEG_N-1:0] hit;
    logic             in_win;

    assign in_win = (r <= R_W'(R_MAX)) && (r >= R_W'(R_MIN));

    always_comb
    begin
        for (int s = 0; s < SEG_N; s++)
        begin
            // An edge value belongs to the segment that ends there
            hit[s] = (r >= R_W'(SEG_END[s])) && ((r < R_W'(SEG_START[s])) || (s == 0));
        end
    end

    always_comb
    begin
        seg.ok    = 1'b0;
        seg.idx   = '0;
        seg.start = SEG_START[0];
        seg.slope = SEG_SLOPE[0];
        // Walk down so the lowest matching segment wins
        for (int s = SEG_N - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                seg.ok    = in_win;
                seg.idx   = SEG_IDX_W'(s);
                seg.start = SEG_START[s];
                seg.slope = SEG_SLOPE[s];
            end
        end
    end

endmodule
`default_nettype wire

/* dv/thermistor_adc_to_temperature_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core_tb
// Self-checking bench for the thermistor ADC to temperature core. A queue of
// ADC codes feeds a bursty valid/ready driver. A monitor predicts Celsius,
// Fahrenheit and in-range for every accepted code, and checks each output
// transaction in order. Directed codes sit on both sides of every segment
// edge. Random codes follow, mostly inside the thermistor range, and the
// output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_core_tb;

    import thm_pkg::C_W;
    import thm_pkg::F_W;
    import thm_pkg::ADC_W;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD_N  = 600;
    localparam int RAND_FIRST_N = 700;
    localparam int RAND_LAST_N  = 800;
    localparam int TIMEOUT      = 2000000 * 2 * CLK_HALF;

    // Divider network and curve table
    localparam int unsigned VREF_MV  = 3300;
    localparam int unsigned PULL_R   = 10000;
    localparam int unsigned OHMS_MAX = 33970;
    localparam int unsigned OHMS_MIN = 2484;
    localparam int unsigned CURVE_N  = 6;
    localparam int unsigned CURVE_HI [CURVE_N] = '{33970, 20310, 12570, 8034, 5298, 3586};
    localparam int unsigned CURVE_LO [CURVE_N] = '{20310, 12570, 8034, 5298, 3586, 2484};
    localparam int unsigned CURVE_K  [CURVE_N] = '{13660, 7740, 4537, 2737, 1717, 1102};

    typedef struct packed {
        logic [C_W-1:0] celsius;
        logic [F_W-1:0] fahrenheit;
        logic           ok;
    } temp_reading_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [ADC_W-1:0] adc_code = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [C_W-1:0]   celsius_centi;
    logic [F_W-1:0]   fahrenheit_centi;
    logic             in_range;

    // Predictor state: last in-range reading
    logic [C_W-1:0] held_c = '0;
    logic [F_W-1:0] held_f = 14'd3200;

    logic [ADC_W-1:0] code_q [$];
    temp_reading_t    reading_q [$];

    logic in_fire = 1'b0;
    int   err_n = 0;
    int   accepted_n = 0;
    int   result_n = 0;
    int   in_range_n = 0;
    int   held_n = 0;
    int   stall_run = 0;
    int   stall_max = 0;

    thermistor_adc_to_temperature_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .adc_code         (adc_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .celsius_centi    (celsius_centi),
        .fahrenheit_centi (fahrenheit_centi),
        .in_range         (in_range)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int unsigned code_to_ohms(input logic [ADC_W-1:0] code);
        int unsigned mv;
        mv = (int'(code) * VREF_MV) >> ADC_W;
        return (PULL_R * mv) / (VREF_MV - mv);
    endfunction

    function automatic int unsigned round_ratio(input int unsigned num, input int unsigned den);
        return (num * 2 + den) / (2 * den);
    endfunction

    // Largest code whose resistance does not exceed the given value
    function automatic int last_code_at_or_below(input int unsigned ohms);
        int found;
        found = -1;
        for (int c = 0; c < (1 << ADC_W); c++)
            if (code_to_ohms(c[ADC_W-1:0]) <= ohms)
                found = c;
        return found;
    endfunction

    // Update the held reading and return what the block should report
    function automatic temp_reading_t convert_code(input logic [ADC_W-1:0] code);
        temp_reading_t res;
        int unsigned   ohms;
        int unsigned   d;
        logic          hit;
        ohms = code_to_ohms(code);
        hit = 1'b0;
        if (ohms <= OHMS_MAX && ohms >= OHMS_MIN) begin
            for (int s = 0; s < CURVE_N; s++) begin
                // an inner edge belongs to the colder segment
                if (!hit && ohms >= CURVE_LO[s] && (ohms < CURVE_HI[s] || s == 0)) begin
                    d = CURVE_HI[s] - ohms;
                    held_c = C_W'(s * 1000 + round_ratio(d * 1000, CURVE_K[s]));
                    held_f = F_W'(3200 + s * 1800 + round_ratio(d * 1800, CURVE_K[s]));
                    hit = 1'b1;
                end
            end
        end
        res.celsius    = held_c;
        res.fahrenheit = held_f;
        res.ok         = hit;
        return res;
    endfunction

    // Driver: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (code_q.size() != 0) begin
                adc_code <= code_q.pop_front();
                in_valid <= 1'b1;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120)
                                                           : $urandom_range(0, 3);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern rotates through four modes, plus one long hold-off
    int  rx_cycle = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge clk) begin : receiver
        logic rdy;
        rx_cycle++;
        if (!long_hold_done && accepted_n >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_N;
        end
        case ((rx_cycle / 256) % 4)
            0:       rdy = 1'b1;
            1:       rdy = $urandom_range(0, 1);
            2:       rdy = (rx_cycle % 5) == 0;
            default: rdy = $urandom_range(0, 3) != 0;
        endcase
        if (hold_left != 0) begin
            hold_left--;
            rdy = 1'b0;
        end
        out_ready <= rst_n && rdy;
    end

    // Monitor: predict on input transactions, check output transactions
    always @(posedge clk) begin : monitor
        temp_reading_t want;
        if (rst_n) begin
            in_fire <= in_valid && in_ready;
            if (in_valid && !in_ready) begin
                stall_run++;
                if (stall_run > stall_max)
                    stall_max = stall_run;
            end else begin
                stall_run = 0;
            end
            if (in_valid && in_ready) begin
                reading_q.push_back(convert_code(adc_code));
                accepted_n++;
            end
            if (out_valid && out_ready) begin
                result_n++;
                if (reading_q.size() == 0) begin
                    $error("output transaction with nothing expected: C=%0d F=%0d ok=%0b",
                           celsius_centi, fahrenheit_centi, in_range);
                    err_n++;
                end else begin
                    want = reading_q.pop_front();
                    if (want.ok)
                        in_range_n++;
                    else
                        held_n++;
                    if (celsius_centi !== want.celsius) begin
                        $error("celsius_centi: expected %0d, got %0d",
                               want.celsius, celsius_centi);
                        err_n++;
                    end
                    if (fahrenheit_centi !== want.fahrenheit) begin
                        $error("fahrenheit_centi: expected %0d, got %0d",
                               want.fahrenheit, fahrenheit_centi);
                        err_n++;
                    end
                    if (in_range !== want.ok) begin
                        $error("in_range: expected %0b, got %0b", want.ok, in_range);
                        err_n++;
                    end
                end
            end
        end
    end

    task automatic queue_random_codes(input int n);
        for (int i = 0; i < n; i++) begin
            // weight toward the thermistor range so most codes hit a segment
            if ($urandom_range(0, 3) != 0)
                code_q.push_back(ADC_W'($urandom_range(190, 800)));
            else
                code_q.push_back(ADC_W'($urandom_range(0, (1 << ADC_W) - 1)));
        end
    endtask

    task automatic wait_all_results();
        while (code_q.size() != 0 || in_valid || reading_q.size() != 0)
            @(posedge clk);
    endtask

    localparam int unsigned EDGES [7] = '{33970, 20310, 12570, 8034, 5298, 3586, 2484};

    initial begin : stimulus
        int c;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset hold value first, then low codes and bit patterns, segment edges, midscale and full scale
        code_q.push_back(ADC_W'(0));
        code_q.push_back(ADC_W'(1));
        code_q.push_back(ADC_W'(10'h155));
        code_q.push_back(ADC_W'(10'h2AA));
        for (int e = 0; e < 7; e++) begin
            c = last_code_at_or_below(EDGES[e]);
            if (c >= 0)
                code_q.push_back(ADC_W'(c));
            if (c + 1 < (1 << ADC_W))
                code_q.push_back(ADC_W'(c + 1));
        end
        code_q.push_back(ADC_W'(512));
        code_q.push_back(ADC_W'((1 << ADC_W) - 1));
        code_q.push_back(ADC_W'(600));
        wait_all_results();

        queue_random_codes(RAND_FIRST_N);
        // Pause the sender until the block has drained completely
        wait_all_results();
        queue_random_codes(RAND_LAST_N);
        wait_all_results();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d codes accepted, %0d results checked (%0d in range, %0d held).",
                 accepted_n, result_n, in_range_n, held_n);
        $display("Summary: longest input stall %0d cycles, all segment edges visited.",
                 stall_max);
        if (err_n == 0 && reading_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/thm_pkg.sv
rtl/core/thm_serial_div.sv
rtl/core/thm_seg_sel.sv
rtl/core/thermistor_adc_to_temperature_core.sv
dv/thermistor_adc_to_temperature_core_tb.sv
